// ----- rtl/core/toy_isa_execute_core_macros.svh -----
// Assertion macros shared by the execute core modules.
// Depends on nothing; included by files that carry assertions.
`ifndef TOY_ISA_EXECUTE_CORE_MACROS_SVH
`define TOY_ISA_EXECUTE_CORE_MACROS_SVH

`define TIE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define TIE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/tiec_pkg.sv -----
// Shared opcodes, modes and divider command types for the execute core.
// Depends on nothing.
`default_nettype none
package tiec_pkg;
  localparam int DATA_DEPTH_DEF  = 4096;
  localparam int STACK_DEPTH_DEF = 256;
  localparam int REG_COUNT       = 8;

  localparam logic [4:0] OP_MOV = 5'd0;
  localparam logic [4:0] OP_LDR = 5'd1;
  localparam logic [4:0] OP_ADD = 5'd2;
  localparam logic [4:0] OP_SUB = 5'd3;
  localparam logic [4:0] OP_MUL = 5'd4;
  localparam logic [4:0] OP_DIV = 5'd5;
  localparam logic [4:0] OP_MOD = 5'd6;
  localparam logic [4:0] OP_INC = 5'd7;
  localparam logic [4:0] OP_AND = 5'd8;
  localparam logic [4:0] OP_OR  = 5'd9;
  localparam logic [4:0] OP_XOR = 5'd10;
  localparam logic [4:0] OP_NOT = 5'd11;
  localparam logic [4:0] OP_SHL = 5'd12;
  localparam logic [4:0] OP_SHR = 5'd13;
  localparam logic [4:0] OP_JMP = 5'd14;
  localparam logic [4:0] OP_JE  = 5'd15;
  localparam logic [4:0] OP_JNE = 5'd16;
  localparam logic [4:0] OP_JG  = 5'd17;
  localparam logic [4:0] OP_JGE = 5'd18;
  localparam logic [4:0] OP_JL  = 5'd19;
  localparam logic [4:0] OP_JLE = 5'd20;
  localparam logic [4:0] OP_CMP = 5'd21;
  localparam logic [4:0] OP_PUSH = 5'd22;
  localparam logic [4:0] OP_POP = 5'd23;
  localparam logic [4:0] OP_CALL = 5'd24;
  localparam logic [4:0] OP_RET = 5'd25;

  localparam logic [1:0] MODE_IMPL  = 2'd0;
  localparam logic [1:0] MODE_REG   = 2'd1;
  localparam logic [1:0] MODE_CONST = 2'd2;
  localparam logic [1:0] MODE_STORE = 2'd3;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [31:0] remainder;
  } div_rsp_t;
endpackage
`default_nettype wire

// ----- rtl/core/tiec_divider.sv -----
// Radix-2 signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on tiec_pkg for the request and response structs.
`default_nettype none
module tiec_divider
  import tiec_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  logic        busy;
  logic [5:0]  count;
  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] dsr;
  logic        neg_q;
  logic        neg_r;
  logic        done;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign shifted = {rem, quo[31]};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= 6'd32;
      end else if (busy) begin
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo   <= req.dividend[31] ? 32'(-req.dividend) : req.dividend;
      dsr   <= req.divisor[31] ? 32'(-req.divisor) : req.divisor;
      rem   <= '0;
      neg_q <= req.dividend[31] ^ req.divisor[31];
      neg_r <= req.dividend[31];
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= shifted[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = neg_q ? 32'(-quo) : quo;
  assign rsp.remainder = neg_r ? 32'(-rem) : rem;

  `include "toy_isa_execute_core_macros.svh"
  `TIE_ASSERT_IMPL(a_no_restart, clk, rst, busy, !req.start, "divider restarted while busy")
  `TIE_ASSERT_NEXT(a_done_once, clk, rst, done, !done, "divider done held two cycles")
  `TIE_ASSERT_IMPL(a_done_idle, clk, rst, done, !busy, "divider done while busy")
endmodule
`default_nettype wire

// ----- rtl/core/toy_isa_execute_core.sv -----
// Execute core of a small eight-register machine. One instruction beat is
// taken at a time; stall stays high until its result beat has been taken.
// Most instructions pass through these steps: the registers are read at the
// accept, memory and stack are read in the next cycle, the instruction then
// executes, and the result beat is offered after that. DIV and MOD with a
// nonzero divisor wait in a divide state between the read and the execute,
// while the divider resolves one quotient bit per cycle. The result beat is
// held while out_stall is high. After reset, a clearing pass writes zero to
// the registers and to every data memory and stack entry, one of each per
// cycle, before the first beat is taken.
// Depends on tiec_pkg, tiec_divider and toy_isa_execute_core_macros.svh.
`default_nettype none
module toy_isa_execute_core
  import tiec_pkg::*;
#(
  parameter int DATA_DEPTH  = DATA_DEPTH_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [4:0]  cmd,
  input  wire logic [1:0]  mode,
  input  wire logic [15:0] first_word,
  input  wire logic [15:0] second_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      next_pc,
  output logic             reg_written,
  output logic [2:0]       reg_index,
  output logic signed [31:0] reg_value,
  output logic             mem_written,
  output logic [11:0]      mem_address,
  output logic [15:0]      mem_value,
  output logic             less_flag,
  output logic             greater_flag,
  output logic             divide_fault
);
  localparam int DAW = $clog2(DATA_DEPTH);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int CLW = (DAW > SAW) ? DAW : SAW;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]  state;
  logic [CLW:0] clr;
  logic [31:0] regs [REG_COUNT];
  logic [15:0] dmem [DATA_DEPTH];
  logic [15:0] smem [STACK_DEPTH];
  logic [SAW-1:0] sp;
  logic [15:0] pc;
  logic        lt;
  logic        gt;
  logic [4:0]  c_cmd;
  logic [1:0]  c_mode;
  logic [15:0] c_w1;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] rs;
  logic [15:0] drd;
  logic [15:0] srd;
  div_req_t    dreq;
  div_rsp_t    drsp;

  logic        has_b;
  logic [2:0]  dst;
  logic        rw;
  logic [31:0] rval;
  logic        mw;
  logic [15:0] npc;
  logic        take;
  logic        lt_next;
  logic        gt_next;
  logic        sp_inc;
  logic        sp_dec;
  logic        push;
  logic [15:0] push_val;
  logic [SAW-1:0] sp_up;

  tiec_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign has_b = (c_mode == MODE_REG) || (c_mode == MODE_CONST);
  assign dst   = c_w1[2:0];
  assign sp_up = sp + 1'b1;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    rw = 1'b0; rval = '0; mw = 1'b0; npc = pc + 16'd3; take = 1'b0;
    lt_next = lt; gt_next = gt; sp_inc = 1'b0; sp_dec = 1'b0;
    push = 1'b0; push_val = '0;
    case (c_cmd)
      OP_MOV: begin
        if (c_mode == MODE_REG) begin
          rw = 1'b1; rval = {16'd0, drd};
        end else if (c_mode == MODE_STORE) begin
          mw = 1'b1;
        end
      end
      OP_LDR: if (has_b) begin rw = 1'b1; rval = b; end
      OP_ADD: if (has_b) begin rw = 1'b1; rval = a + b; end
      OP_SUB: if (has_b) begin rw = 1'b1; rval = a - b; end
      OP_MUL: if (has_b) begin rw = 1'b1; rval = a * b; end
      OP_DIV, OP_MOD: begin
        if (has_b && b != '0) begin
          rw = 1'b1;
          rval = (c_cmd == OP_DIV) ? drsp.quotient : drsp.remainder;
        end
      end
      OP_INC: begin rw = 1'b1; rval = a + 32'd1; npc = pc + 16'd2; end
      OP_AND: if (has_b) begin rw = 1'b1; rval = a & b; end
      OP_OR:  if (has_b) begin rw = 1'b1; rval = a | b; end
      OP_XOR: if (has_b) begin rw = 1'b1; rval = a ^ b; end
      OP_NOT: begin rw = 1'b1; rval = ~rs; end
      OP_SHL: if (has_b) begin
        rw = 1'b1; rval = (b >= 32'd32) ? 32'd0 : (a << b[4:0]);
      end
      OP_SHR: if (has_b) begin
        rw = 1'b1;
        rval = (b >= 32'd32) ? {32{a[31]}} : 32'($signed(a) >>> b[4:0]);
      end
      OP_JMP, OP_JE, OP_JNE, OP_JG, OP_JGE, OP_JL, OP_JLE: begin
        case (c_cmd)
          OP_JMP: take = 1'b1;
          OP_JE:  take = !lt && !gt;
          OP_JNE: take = lt || gt;
          OP_JG:  take = gt;
          OP_JGE: take = !lt;
          OP_JL:  take = lt;
          default: take = !gt;
        endcase
        npc = take ? c_w1 : pc + 16'd2;
      end
      OP_CMP: if (has_b) begin
        lt_next = $signed(a) < $signed(b);
        gt_next = $signed(a) > $signed(b);
      end
      OP_PUSH: begin
        npc = pc + 16'd2;
        if (has_b) begin
          sp_inc = 1'b1; push = 1'b1;
          push_val = (c_mode == MODE_REG) ? a[15:0] : c_w1;
        end
      end
      OP_POP: begin
        rw = 1'b1; rval = {16'd0, srd}; sp_dec = 1'b1; npc = pc + 16'd2;
      end
      OP_CALL: begin
        sp_inc = 1'b1; push = 1'b1; push_val = pc + 16'd2; npc = c_w1;
      end
      OP_RET: begin npc = srd; sp_dec = 1'b1; end
      default: npc = pc + 16'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      if (clr < (CLW+1)'(DATA_DEPTH)) dmem[clr[DAW-1:0]] <= '0;
    end else if (state == S_EXEC && mw) begin
      dmem[a[DAW-1:0]] <= rs[15:0];
    end
    if (state == S_READ) drd <= dmem[rs[DAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      if (clr < (CLW+1)'(STACK_DEPTH)) smem[clr[SAW-1:0]] <= '0;
    end else if (state == S_EXEC && push) begin
      smem[sp_up] <= push_val;
    end
    if (state == S_READ) srd <= smem[sp];
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      regs[clr[2:0]] <= '0;
    end else if ((state == S_EXEC) && rw) begin
      regs[dst] <= rval;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      c_cmd <= cmd; c_mode <= mode; c_w1 <= first_word;
      a  <= regs[first_word[2:0]];
      rs <= regs[second_word[2:0]];
      b  <= (mode == MODE_REG) ? regs[second_word[2:0]] : {16'd0, second_word};
    end
    if (state == S_EXEC) begin
      next_pc <= npc;
      reg_written <= rw;
      reg_index <= rw ? dst : 3'd0;
      reg_value <= rw ? rval : 32'd0;
      mem_written <= mw;
      mem_address <= mw ? 12'(a[DAW-1:0]) : 12'd0;
      mem_value <= mw ? rs[15:0] : 16'd0;
      less_flag <= lt_next;
      greater_flag <= gt_next;
      divide_fault <= ((c_cmd == OP_DIV) || (c_cmd == OP_MOD)) && has_b && (b == '0);
    end
  end

  always_comb begin
    dreq.start    = (state == S_READ) && ((c_cmd == OP_DIV) || (c_cmd == OP_MOD))
                    && has_b && (b != '0);
    dreq.dividend = a;
    dreq.divisor  = b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr <= '0; sp <= '0; pc <= '0; lt <= 1'b0; gt <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (CLW+1)'((DATA_DEPTH > STACK_DEPTH) ? DATA_DEPTH - 1 : STACK_DEPTH - 1))
            state <= S_IDLE;
        end
        S_IDLE: if (in_valid) state <= S_READ;
        S_READ: state <= dreq.start ? S_DIV : S_EXEC;
        S_DIV:  if (drsp.done) state <= S_EXEC;
        S_EXEC: begin
          pc <= npc; lt <= lt_next; gt <= gt_next;
          if (sp_inc) sp <= sp_up;
          if (sp_dec) sp <= sp - 1'b1;
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (!out_stall) begin out_valid <= 1'b0; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "toy_isa_execute_core_macros.svh"
  `TIE_ASSERT_IMPL(a_valid_state, clk, rst, out_valid, state == S_OUT, "result without pending beat")
  `TIE_ASSERT_IMPL(a_no_accept_busy, clk, rst, state != S_IDLE, in_stall, "input open while busy")
  `TIE_ASSERT_NEXT(a_exec_once, clk, rst, state == S_EXEC, state == S_OUT, "execute not followed by result")
endmodule
`default_nettype wire
